### hw/rtl/box_muller_gaussian_pair_core_defines.svh
// Assertion helpers used by the core's top-level module.
`ifndef BOX_MULLER_GAUSSIAN_PAIR_CORE_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_PAIR_CORE_DEFINES_SVH

// Check an implication on every edge outside reset.
`define BMG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmg assertion failed");

// Check an implication in the next cycle, with no reset gating.
`define BMG_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bmg assertion failed");

`endif

### hw/rtl/bmg_pkg.sv
package bmg_pkg;

  localparam int UNIFORM_BITS_DEF = 32;
  localparam int OUTPUT_BITS_DEF  = 16;
  localparam int LOG_FRAC         = 30;
  localparam int WORK_FRAC        = 28;
  localparam int ROT_ROUNDS       = 24;
  localparam int PHASE_BITS       = 32;
  localparam int ANGLE_BITS       = 32;

  // 2 ln 2 in Q26 and 1/K in Q30
  localparam logic [26:0] TWO_LN2_Q26  = 27'd93032640;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  typedef struct packed {
    logic                  valid;
    logic [PHASE_BITS-1:0] phase;
  } ctl_t;

  // arctangent of 2^-i in turns, full turn = 2^32
  function automatic logic [ANGLE_BITS-1:0] atan_turn(input int idx);
    logic [ANGLE_BITS-1:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/bmg_req_if.sv
interface bmg_req_if #(parameter int UNIFORM_BITS = 32);
  logic                    valid;
  logic                    ready;
  logic [UNIFORM_BITS-1:0] u1_fraction;
  logic [UNIFORM_BITS-1:0] u2_fraction;

  modport source (output valid, output u1_fraction, output u2_fraction, input ready);
  modport sink   (input valid, input u1_fraction, input u2_fraction, output ready);
endinterface

### hw/rtl/bmg_res_if.sv
interface bmg_res_if #(parameter int OUTPUT_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [OUTPUT_BITS-1:0] gauss_cos;
  logic signed [OUTPUT_BITS-1:0] gauss_sin;

  modport source (output valid, output gauss_cos, output gauss_sin, input ready);
  modport sink   (input valid, input gauss_cos, input gauss_sin, output ready);
endinterface

### hw/rtl/bmg_log2.sv
module bmg_log2 import bmg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF,
  localparam int EW = $clog2(UNIFORM_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  ctl_t                    in_ctl,
  input  logic [UNIFORM_BITS-1:0] u1,
  output ctl_t                    out_ctl,
  output logic [EW-1:0]           expo,
  output logic [LOG_FRAC-1:0]     frac
);

  logic                  v_q  [0:LOG_FRAC];
  logic [PHASE_BITS-1:0] ph_q [0:LOG_FRAC];
  logic [LOG_FRAC:0]     m_q  [0:LOG_FRAC];
  logic [EW-1:0]         e_q  [0:LOG_FRAC];
  logic [LOG_FRAC-1:0]   f_q  [0:LOG_FRAC];

  logic [UNIFORM_BITS-1:0]          u1c;
  logic [EW-1:0]                    lead;
  logic [UNIFORM_BITS+LOG_FRAC-1:0] ext;

  // clamp zero, find leading one, normalize to Q1.30
  always_comb begin
    u1c  = (u1 == '0) ? UNIFORM_BITS'(1) : u1;
    lead = '0;
    for (int k = 0; k < UNIFORM_BITS; k++) begin
      if (u1c[k]) lead = EW'(k);
    end
    ext = {u1c, {LOG_FRAC{1'b0}}} >> lead;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_ctl.valid;
    end
    if (adv) begin
      ph_q[0] <= in_ctl.phase;
      m_q[0]  <= ext[LOG_FRAC:0];
      e_q[0]  <= lead;
      f_q[0]  <= '0;
    end
  end

  // one squaring per stage yields one fraction bit
  for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_sq
    logic [2*LOG_FRAC+1:0] sq;
    logic [LOG_FRAC+1:0]   p;
    logic [LOG_FRAC-1:0]   f_next;
    always_comb begin
      sq = (2*LOG_FRAC+2)'(m_q[i-1]) * (2*LOG_FRAC+2)'(m_q[i-1]);
      p  = sq[2*LOG_FRAC+1:LOG_FRAC];
      f_next = f_q[i-1];
      f_next[LOG_FRAC-i] = p[LOG_FRAC+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (adv) begin
        v_q[i] <= v_q[i-1];
      end
      if (adv) begin
        ph_q[i] <= ph_q[i-1];
        m_q[i]  <= p[LOG_FRAC+1] ? p[LOG_FRAC+1:1] : p[LOG_FRAC:0];
        e_q[i]  <= e_q[i-1];
        f_q[i]  <= f_next;
      end
    end
  end

  assign out_ctl.valid = v_q[LOG_FRAC];
  assign out_ctl.phase = ph_q[LOG_FRAC];
  assign expo          = e_q[LOG_FRAC];
  assign frac          = f_q[LOG_FRAC];

endmodule

### hw/rtl/bmg_sqrt.sv
module bmg_sqrt import bmg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF,
  localparam int EW  = $clog2(UNIFORM_BITS),
  localparam int NW  = $clog2(UNIFORM_BITS + 1),
  localparam int TW  = NW + LOG_FRAC,
  localparam int SW  = TW + 1,
  localparam int RDW = ((SW + 26 + 1) / 2) * 2,
  localparam int NS  = RDW / 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  ctl_t                in_ctl,
  input  logic [EW-1:0]       expo,
  input  logic [LOG_FRAC-1:0] frac,
  output ctl_t                out_ctl,
  output logic [NS-1:0]       root
);

  localparam int PW = TW + 27;

  logic                  tv_q;
  logic [PHASE_BITS-1:0] tph_q;
  logic [TW-1:0]         t_q;
  logic [NW-1:0]         n;
  logic [PW-1:0]         prod;

  logic                  v_q   [0:NS];
  logic [PHASE_BITS-1:0] ph_q  [0:NS];
  logic [NS+1:0]         rem_q [0:NS];
  logic [NS-1:0]         rt_q  [0:NS];
  logic [RDW-1:0]        rad_q [0:NS];

  // -log2(u1) in Q30, then scale by 2 ln 2
  assign n    = NW'(UNIFORM_BITS) - NW'(expo);
  assign prod = PW'(t_q) * PW'(TWO_LN2_Q26);

  always_ff @(posedge clk) begin
    if (rst) begin
      tv_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (adv) begin
      tv_q   <= in_ctl.valid;
      v_q[0] <= tv_q;
    end
    if (adv) begin
      tph_q     <= in_ctl.phase;
      t_q       <= {n, {LOG_FRAC{1'b0}}} - TW'(frac);
      ph_q[0]   <= tph_q;
      rem_q[0]  <= '0;
      rt_q[0]   <= '0;
      rad_q[0]  <= RDW'(prod[PW-1:26]) << 26;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_rt
    logic [NS+1:0] pre;
    logic [NS+1:0] trial;
    assign pre   = {rem_q[k][NS-1:0], rad_q[k][RDW-1 -: 2]};
    assign trial = {rt_q[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
      if (adv) begin
        ph_q[k+1]  <= ph_q[k];
        rad_q[k+1] <= rad_q[k] << 2;
        if (pre >= trial) begin
          rem_q[k+1] <= pre - trial;
          rt_q[k+1]  <= {rt_q[k][NS-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= pre;
          rt_q[k+1]  <= {rt_q[k][NS-2:0], 1'b0};
        end
      end
    end
  end

  assign out_ctl.valid = v_q[NS];
  assign out_ctl.phase = ph_q[NS];
  assign root          = rt_q[NS];

endmodule

### hw/rtl/bmg_cordic.sv
module bmg_cordic import bmg_pkg::*; #(
  parameter int NS          = 31,
  parameter int OUTPUT_BITS = OUTPUT_BITS_DEF,
  localparam int XW = NS + 2,
  localparam int VW = XW + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  ctl_t                          in_ctl,
  input  logic [NS-1:0]                 root,
  output logic                          out_valid,
  output logic signed [OUTPUT_BITS-1:0] out_cos,
  output logic signed [OUTPUT_BITS-1:0] out_sin
);

  localparam int SH = WORK_FRAC - (OUTPUT_BITS - 5);
  localparam int PW = NS + 30;
  localparam logic signed [VW-1:0] HI = VW'((2**(OUTPUT_BITS-1)) - 1);
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);
  localparam logic signed [VW-1:0] HALF = VW'(1) <<< (SH - 1);

  logic                         v_q  [0:ROT_ROUNDS];
  logic [1:0]                   qd_q [0:ROT_ROUNDS];
  logic signed [XW-1:0]         x_q  [0:ROT_ROUNDS];
  logic signed [XW-1:0]         y_q  [0:ROT_ROUNDS];
  logic signed [ANGLE_BITS-1:0] z_q  [0:ROT_ROUNDS];
  logic [PW-1:0]                gprod;

  // round to nearest with ties up, then clamp
  function automatic logic signed [OUTPUT_BITS-1:0] pack(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v + HALF) >>> SH;
    if (r > HI) r = HI;
    if (r < LO) r = LO;
    return OUTPUT_BITS'(r);
  endfunction

  assign gprod = PW'(root) * PW'(INV_GAIN_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_ctl.valid;
    end
    if (adv) begin
      qd_q[0] <= in_ctl.phase[PHASE_BITS-1 -: 2];
      x_q[0]  <= signed'(XW'(gprod[PW-1:30]));
      y_q[0]  <= '0;
      z_q[0]  <= signed'({2'b00, in_ctl.phase[PHASE_BITS-3:0]});
    end
  end

  for (genvar i = 0; i < ROT_ROUNDS; i++) begin : g_rot
    logic signed [XW-1:0]         xs;
    logic signed [XW-1:0]         ys;
    logic signed [ANGLE_BITS-1:0] at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = signed'(atan_turn(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else if (adv) begin
        v_q[i+1] <= v_q[i];
      end
      if (adv) begin
        qd_q[i+1] <= qd_q[i];
        if (!z_q[i][ANGLE_BITS-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  logic signed [VW-1:0] xe, ye, mx, my;

  // fold the quadrant back in
  always_comb begin
    xe = VW'(x_q[ROT_ROUNDS]);
    ye = VW'(y_q[ROT_ROUNDS]);
    case (qd_q[ROT_ROUNDS])
      2'd1:    begin mx = -ye; my = xe;  end
      2'd2:    begin mx = -xe; my = -ye; end
      2'd3:    begin mx = ye;  my = -xe; end
      default: begin mx = xe;  my = ye;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_q[ROT_ROUNDS];
    end
    if (adv) begin
      out_cos <= pack(mx);
      out_sin <= pack(my);
    end
  end

endmodule

### hw/rtl/box_muller_gaussian_pair_core.sv
// Channel  Dir  Payload                              Handshake
// req_ch   in   u1_fraction, u2_fraction (unsigned)  valid/ready
// res_ch   out  gauss_cos, gauss_sin (signed Q5.x)   valid/ready
//
// One request enters per clock unless a blocked result stalls the pipe; every
// stage holds a valid bit beside its data. There are 31 log2 stages (normalize
// plus 30 squarings), NS + 2 root stages (NS = 32 at 32-bit inputs), 26 CORDIC stages.
// Synchronous active-high rst clears all valid bits; payload is not reset.
// When a result waits and res_ch.ready is low, the whole pipe holds in place.
`include "box_muller_gaussian_pair_core_defines.svh"

module box_muller_gaussian_pair_core import bmg_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF,
  parameter int OUTPUT_BITS  = OUTPUT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  bmg_req_if.sink  req_ch,
  bmg_res_if.source res_ch
);

  localparam int EW  = $clog2(UNIFORM_BITS);
  localparam int NW  = $clog2(UNIFORM_BITS + 1);
  localparam int SW  = NW + LOG_FRAC + 1;
  localparam int RDW = ((SW + 26 + 1) / 2) * 2;
  localparam int NS  = RDW / 2;

  logic                  adv;
  logic [PHASE_BITS-1:0] phase;
  ctl_t                  in_ctl, log_ctl, rt_ctl;
  logic [EW-1:0]         expo;
  logic [LOG_FRAC-1:0]   frac;
  logic [NS-1:0]         root;

  // advance everything unless the output slot is full and blocked
  assign adv          = !res_ch.valid || res_ch.ready;
  assign req_ch.ready = adv;

  // scale u2 to a 32-bit phase word
  if (UNIFORM_BITS >= PHASE_BITS) begin : g_ph_hi
    assign phase = req_ch.u2_fraction[UNIFORM_BITS-1 -: PHASE_BITS];
  end else begin : g_ph_lo
    assign phase = {req_ch.u2_fraction, {(PHASE_BITS-UNIFORM_BITS){1'b0}}};
  end

  assign in_ctl.valid = req_ch.valid;
  assign in_ctl.phase = phase;

  // -log2(u1): normalize, then one squaring per stage
  bmg_log2 #(.UNIFORM_BITS(UNIFORM_BITS)) u_log2 (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_ctl  (in_ctl),
    .u1      (req_ch.u1_fraction),
    .out_ctl (log_ctl),
    .expo    (expo),
    .frac    (frac)
  );

  // radius = sqrt(-2 ln u1) in Q28
  bmg_sqrt #(.UNIFORM_BITS(UNIFORM_BITS)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_ctl  (log_ctl),
    .expo    (expo),
    .frac    (frac),
    .out_ctl (rt_ctl),
    .root    (root)
  );

  // rotate the radius by the phase, round, and hold in the output register
  bmg_cordic #(.NS(NS), .OUTPUT_BITS(OUTPUT_BITS)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_ctl    (rt_ctl),
    .root      (root),
    .out_valid (res_ch.valid),
    .out_cos   (res_ch.gauss_cos),
    .out_sin   (res_ch.gauss_sin)
  );

  // a blocked result must stall the intake
  `BMG_ASSERT_IMP(a_stall_blocks_req, clk, rst, res_ch.valid && !res_ch.ready, !req_ch.ready)
  // a blocked result stays on offer
  `BMG_ASSERT_NEXT(a_blocked_held, clk, !rst && res_ch.valid && !res_ch.ready, res_ch.valid)
  // reset empties the output slot
  `BMG_ASSERT_NEXT(a_reset_clears, clk, rst, !res_ch.valid)

endmodule
